>>> sv/grff_pkg.sv
// Shared constants, payload and handshake types of the gated residual feature fusion block
package grff_pkg;

  // Fixed-point format and set limits
  localparam int FRAC_BITS = 14;
  localparam int MAX_ITEMS = 65536;

  // Shared divider geometry: quotient bits resolved one per cycle
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_Q_W   = 20;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_Q_W);

  localparam logic [16:0] ONE_FX    = 17'(1 << FRAC_BITS);
  localparam logic [35:0] HALF_FX   = 36'(1 << (FRAC_BITS - 1));
  localparam logic [16:0] MAX_COUNT = 17'(MAX_ITEMS);
  localparam logic [19:0] OUT_MAX   = 20'hFFFFF;

  // Item commands
  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_OUTPUT = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic signed [15:0] c_value;
    logic               gather_last;
    logic               output_first;
  } grff_in_t;

  typedef struct packed {
    logic [19:0] fused_value;
    logic        saturated;
  } grff_out_t;

  // Divider request: magnitude operands plus the sign of the quotient
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic                 neg;
  } grff_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [20:0] quot;
  } grff_div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_G_GO,
    ST_G_WAIT,
    ST_GATHER,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_SMOOTH,
    ST_MUL_BG,
    ST_MUL_BA,
    ST_S_GO,
    ST_S_WAIT,
    ST_MUL_SC,
    ST_SUM_HB,
    ST_E_GO,
    ST_E_WAIT,
    ST_EMIT
  } grff_state_e;

endpackage

>>> sv/grff_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero
module grff_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  grff_pkg::grff_div_req_t req_i,
  output grff_pkg::grff_div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [grff_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [grff_pkg::DIV_DEN_W:0]        rem_q;
  logic [grff_pkg::DIV_Q_W-1:0]        shf_q;
  logic [grff_pkg::DIV_DEN_W-1:0]      den_q;
  logic                                neg_q;

  logic [grff_pkg::DIV_DEN_W:0]        trial;
  logic                                fits;
  logic [grff_pkg::DIV_DEN_W:0]        rem_d;

  // One compare-and-subtract step; caller keeps num >> DIV_Q_W below den
  always_comb begin
    trial = {rem_q[grff_pkg::DIV_DEN_W-1:0], shf_q[grff_pkg::DIV_Q_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? (trial - {1'b0, den_q}) : trial;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= grff_pkg::DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == grff_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift register carries dividend bits in and quotient bits out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= (grff_pkg::DIV_DEN_W + 1)'(req_i.num[grff_pkg::DIV_NUM_W-1:grff_pkg::DIV_Q_W]);
      shf_q <= req_i.num[grff_pkg::DIV_Q_W-1:0];
      den_q <= req_i.den;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= {shf_q[grff_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, shf_q}) : $signed({1'b0, shf_q});

endmodule

>>> sv/gated_residual_feature_fusion.sv
// Top level: sequencer, shared multiplier, state registers and output register
//
// Gated residual feature fusion. Items arrive on the in_* valid/ready channel;
// results leave on the out_* valid/ready channel, one per output item (command
// 1) and none per gather item (command 0). One item is processed at a time:
// in_ready_o is high only while the sequencer is idle.
// Work per item, set by the shared 20-step divider (one quotient bit a cycle)
// and the single multiplier:
//   gather item              one product and one division (the gate)
//   gather item with last    adds the average division
//   output item              three divisions, four products
// The result sits in an output register; the next item is accepted while it
// waits. If a second result is ready before the first is taken, the sequencer
// holds in its final state until the output register frees up.
// Reset clears the running sum, item count, average, previous residual and
// the output valid; a transfer can be taken as soon as reset is released.
module gated_residual_feature_fusion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  grff_pkg::grff_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output grff_pkg::grff_out_t out_data_o
);

  grff_pkg::grff_state_e   state_q, state_d;
  grff_pkg::grff_div_req_t div_req;
  grff_pkg::grff_div_rsp_t div_rsp;

  // Item and intermediate registers
  grff_pkg::grff_in_t  in_q;
  logic signed [17:0]  p_q;
  logic [14:0]         g_q;
  logic signed [16:0]  ap_q;
  logic signed [16:0]  s_q;
  logic signed [16:0]  t_q;
  logic signed [17:0]  bp_q;
  logic signed [16:0]  cp_q;
  logic signed [18:0]  h_q;
  logic signed [19:0]  hb_q;
  logic signed [21:0]  r_q;

  // Persistent state
  logic signed [35:0]  sum_q;
  logic [16:0]         count_q;
  logic signed [16:0]  avg_q;
  logic signed [16:0]  prev_q;

  // Output register
  grff_pkg::grff_out_t out_q;
  logic                out_valid_q;

  logic                in_xfer;
  logic                out_free;

  // Shared multiplier with round-half-up back to the fraction width
  logic signed [17:0]  mul_a, mul_b;
  logic signed [35:0]  mul_p;
  logic [35:0]         mul_rs;
  logic signed [21:0]  mul_r;

  // Derived values
  logic [16:0]         abs_p, abs_s;
  logic [19:0]         abs_hb;
  logic [35:0]         abs_sum;
  logic [20:0]         gsum;
  logic [17:0]         sm_sum;
  logic [14:0]         one_minus_g;

  grff_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    abs_p       = p_q[17] ? 17'(-p_q) : 17'(p_q);
    abs_s       = s_q[16] ? 17'(-s_q) : 17'(s_q);
    abs_hb      = hb_q[19] ? 20'(-hb_q) : 20'(hb_q);
    abs_sum     = sum_q[35] ? 36'(-sum_q) : 36'(sum_q);
    gsum        = 21'(div_rsp.quot) + 21'(grff_pkg::ONE_FX);
    sm_sum      = 18'(ap_q) + 18'(prev_q);
    one_minus_g = 15'(grff_pkg::ONE_FX) - g_q;
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      grff_pkg::ST_MUL_AB: begin
        mul_a = 18'(in_q.a_value);
        mul_b = 18'(in_q.b_value);
      end
      grff_pkg::ST_MUL_BG: begin
        mul_a = 18'(in_q.b_value);
        mul_b = $signed({3'b000, one_minus_g});
      end
      grff_pkg::ST_MUL_BA: begin
        mul_a = 18'(t_q);
        mul_b = 18'(avg_q);
      end
      grff_pkg::ST_MUL_SC: begin
        mul_a = 18'(s_q);
        mul_b = 18'(cp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p  = mul_a * mul_b;
    mul_rs = mul_p + grff_pkg::HALF_FX;
    mul_r  = 22'($signed(mul_rs) >>> grff_pkg::FRAC_BITS);
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grff_pkg::ST_IDLE:     if (in_xfer) state_d = grff_pkg::ST_MUL_AB;
      grff_pkg::ST_MUL_AB:   state_d = grff_pkg::ST_G_GO;
      grff_pkg::ST_G_GO:     state_d = grff_pkg::ST_G_WAIT;
      grff_pkg::ST_G_WAIT: begin
        if (div_rsp.done) begin
          state_d = (in_q.command == grff_pkg::CMD_OUTPUT) ? grff_pkg::ST_SMOOTH
                                                           : grff_pkg::ST_GATHER;
        end
      end
      grff_pkg::ST_GATHER:
        state_d = in_q.gather_last ? grff_pkg::ST_AVG_GO : grff_pkg::ST_IDLE;
      grff_pkg::ST_AVG_GO:
        state_d = (count_q == '0) ? grff_pkg::ST_IDLE : grff_pkg::ST_AVG_WAIT;
      grff_pkg::ST_AVG_WAIT: if (div_rsp.done) state_d = grff_pkg::ST_IDLE;
      grff_pkg::ST_SMOOTH:   state_d = grff_pkg::ST_MUL_BG;
      grff_pkg::ST_MUL_BG:   state_d = grff_pkg::ST_MUL_BA;
      grff_pkg::ST_MUL_BA:   state_d = grff_pkg::ST_S_GO;
      grff_pkg::ST_S_GO:     state_d = grff_pkg::ST_S_WAIT;
      grff_pkg::ST_S_WAIT:   if (div_rsp.done) state_d = grff_pkg::ST_MUL_SC;
      grff_pkg::ST_MUL_SC:   state_d = grff_pkg::ST_SUM_HB;
      grff_pkg::ST_SUM_HB:   state_d = grff_pkg::ST_E_GO;
      grff_pkg::ST_E_GO:     state_d = grff_pkg::ST_E_WAIT;
      grff_pkg::ST_E_WAIT:   if (div_rsp.done) state_d = grff_pkg::ST_EMIT;
      grff_pkg::ST_EMIT:     if (out_free) state_d = grff_pkg::ST_IDLE;
      default:               state_d = grff_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and divider requests
  always_comb begin
    in_ready_o    = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.neg   = 1'b0;
    unique case (state_q)
      grff_pkg::ST_IDLE: in_ready_o = 1'b1;
      grff_pkg::ST_G_GO: begin
        // softsign of the product a*b
        div_req.start = 1'b1;
        div_req.num   = 36'(abs_p) << grff_pkg::FRAC_BITS;
        div_req.den   = grff_pkg::ONE_FX + abs_p;
        div_req.neg   = p_q[17];
      end
      grff_pkg::ST_AVG_GO: begin
        div_req.start = (count_q != '0);
        div_req.num   = abs_sum;
        div_req.den   = count_q;
        div_req.neg   = sum_q[35];
      end
      grff_pkg::ST_S_GO: begin
        div_req.start = 1'b1;
        div_req.num   = 36'(abs_s) << grff_pkg::FRAC_BITS;
        div_req.den   = grff_pkg::ONE_FX + abs_s;
        div_req.neg   = s_q[16];
      end
      grff_pkg::ST_E_GO: begin
        // normalisation of s*c' + b' by 1 + |s|
        div_req.start = 1'b1;
        div_req.num   = 36'(abs_hb) << grff_pkg::FRAC_BITS;
        div_req.den   = grff_pkg::ONE_FX + abs_s;
        div_req.neg   = hb_q[19];
      end
      default: begin
        in_ready_o    = 1'b0;
        div_req.start = 1'b0;
      end
    endcase
  end

  // State register and persistent block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grff_pkg::ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      avg_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Output valid: set on leaving the final state, cleared once taken
      if (state_q == grff_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        grff_pkg::ST_GATHER: begin
          // a full set drops further residuals
          if (count_q < grff_pkg::MAX_COUNT) begin
            sum_q   <= sum_q + 36'(ap_q);
            count_q <= count_q + 1'b1;
          end
        end
        grff_pkg::ST_AVG_GO: begin
          if (count_q == '0) begin
            avg_q <= '0;
            sum_q <= '0;
          end
        end
        grff_pkg::ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg_q   <= div_rsp.quot[16:0];
            sum_q   <= '0;
            count_q <= '0;
          end
        end
        grff_pkg::ST_SMOOTH: prev_q <= ap_q;
        default: ;
      endcase
    end
  end

  // Item datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      grff_pkg::ST_IDLE:   if (in_xfer) in_q <= in_data_i;
      grff_pkg::ST_MUL_AB: p_q <= mul_r[17:0];
      grff_pkg::ST_G_WAIT: begin
        if (div_rsp.done) begin
          g_q  <= gsum[15:1];
          ap_q <= 17'(in_q.a_value) + 17'(gsum[15:1]);
        end
      end
      grff_pkg::ST_SMOOTH: s_q <= in_q.output_first ? ap_q : $signed(sm_sum[17:1]);
      grff_pkg::ST_MUL_BG: t_q <= mul_r[16:0];
      grff_pkg::ST_MUL_BA: bp_q <= mul_r[17:0];
      grff_pkg::ST_S_WAIT: begin
        if (div_rsp.done) cp_q <= 17'(in_q.c_value) + div_rsp.quot[16:0];
      end
      grff_pkg::ST_MUL_SC: h_q <= mul_r[18:0];
      grff_pkg::ST_SUM_HB: hb_q <= 20'(h_q) + 20'(bp_q);
      grff_pkg::ST_E_WAIT: begin
        if (div_rsp.done) r_q <= 22'(cp_q) - 22'(div_rsp.quot);
      end
      grff_pkg::ST_EMIT: begin
        // ReLU with saturation at the 20-bit maximum
        if (out_free) begin
          if (r_q > $signed({2'b00, grff_pkg::OUT_MAX})) begin
            out_q.fused_value <= grff_pkg::OUT_MAX;
            out_q.saturated   <= 1'b1;
          end else if (r_q > 22'sd0) begin
            out_q.fused_value <= r_q[19:0];
            out_q.saturated   <= 1'b0;
          end else begin
            out_q.fused_value <= '0;
            out_q.saturated   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> verif/grff_result_checker.sv
// Result checker for the gated residual feature fusion block: predicts and compares
module grff_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  grff_pkg::grff_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  grff_pkg::grff_out_t out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  // Fixed-point unit and clip limits of the residual and its running sum
  localparam longint FX_ONE   = longint'(1) << grff_pkg::FRAC_BITS;
  localparam longint RESID_HI = 65535;
  localparam longint RESID_LO = -65536;
  localparam longint SUM_HI   = (longint'(1) << 35) - 1;
  localparam longint SUM_LO   = -(longint'(1) << 35);
  localparam longint FUSED_HI = longint'(grff_pkg::OUT_MAX);

  // Predicted block state
  longint resid_sum;
  longint set_count;
  longint resid_avg;
  longint prev_resid;

  // Fused results still owed by the block, oldest first
  grff_pkg::grff_out_t fused_expect_q[$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic longint div_floor(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // product back to FRAC_BITS, rounded half up
  function automatic longint fx_product(input longint x, input longint y);
    return div_floor(x * y + FX_ONE / 2, FX_ONE);
  endfunction

  // x / (1 + |x|), truncated toward zero
  function automatic longint squash(input longint x);
    longint mag;
    mag = (x < 0) ? -x : x;
    return (x * FX_ONE) / (FX_ONE + mag);
  endfunction

  function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint fusion_gate(input longint a, input longint b);
    return div_floor(squash(fx_product(a, b)) + FX_ONE, 2);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  // Update the predicted state for one item; output items owe one result
  task automatic predict_fusion(input grff_pkg::grff_in_t item);
    longint a, b, c, g, resid, s, mag, den, cp, bp, h, e, r;
    grff_pkg::grff_out_t want;
    a = longint'($signed(item.a_value));
    b = longint'($signed(item.b_value));
    c = longint'($signed(item.c_value));
    g = fusion_gate(a, b);
    resid = clamp_to(a + g, RESID_LO, RESID_HI);
    if (item.command == grff_pkg::CMD_GATHER) begin
      // a full set takes no more items, but a last mark still closes it
      if (set_count < grff_pkg::MAX_ITEMS) begin
        resid_sum = clamp_to(resid_sum + resid, SUM_LO, SUM_HI);
        set_count = set_count + 1;
      end
      if (item.gather_last) begin
        resid_avg = (set_count == 0) ? 0 :
                    clamp_to(resid_sum / set_count, RESID_LO, RESID_HI);
        resid_sum = 0;
        set_count = 0;
      end
    end else begin
      s = item.output_first ? resid : div_floor(resid + prev_resid, 2);
      prev_resid = resid;
      mag = (s < 0) ? -s : s;
      den = FX_ONE + mag;
      cp = c + squash(s);
      bp = fx_product(fx_product(b, FX_ONE - g), resid_avg);
      h = fx_product(s, cp);
      e = ((h + bp) * FX_ONE) / den;
      r = cp - e;
      // ReLU with saturation flag
      if (r > FUSED_HI) begin
        want.fused_value = grff_pkg::OUT_MAX;
        want.saturated   = 1'b1;
      end else if (r > 0) begin
        want.fused_value = 20'(r);
        want.saturated   = 1'b0;
      end else begin
        want.fused_value = '0;
        want.saturated   = 1'b0;
      end
      fused_expect_q.push_back(want);
    end
  endtask

  // Results are checked before the same edge's input transfer is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    grff_pkg::grff_out_t want;
    if (!rst_ni) begin
      resid_sum  = 0;
      set_count  = 0;
      resid_avg  = 0;
      prev_resid = 0;
      fused_expect_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (fused_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending, fused_value",
                          longint'(out_data_i.fused_value), 0);
        end else begin
          want = fused_expect_q.pop_front();
          if (out_data_i.fused_value !== want.fused_value)
            report_mismatch("fused_value", longint'(out_data_i.fused_value),
                            longint'(want.fused_value));
          if (out_data_i.saturated !== want.saturated)
            report_mismatch("saturated", longint'(out_data_i.saturated),
                            longint'(want.saturated));
        end
      end
      if (in_valid_i && in_ready_i) predict_fusion(in_data_i);
      pending_o = fused_expect_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top: drives items into the fusion block and gives the verdict
module tb;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  grff_pkg::grff_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  grff_pkg::grff_out_t out_data_o;

  // Idle chance per cycle, in percent, for each side
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches;
  int pending;

  gated_residual_feature_fusion dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  grff_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly wide random values, with extremes and values within +-2.0 mixed in
  function automatic logic signed [15:0] pick_feature();
    unique case ($urandom_range(7))
      0: begin
        unique case ($urandom_range(5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          4: return 16'sh4000;
          default: return 16'shC000;
        endcase
      end
      1, 2: return 16'($urandom_range(4 * 16384) - 2 * 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic cmd, input logic signed [15:0] a,
                           input logic signed [15:0] b, input logic signed [15:0] c,
                           input logic mark_last, input logic mark_first);
    grff_pkg::grff_in_t item;
    item.command      = cmd;
    item.a_value      = a;
    item.b_value      = b;
    item.c_value      = c;
    item.gather_last  = mark_last;
    item.output_first = mark_first;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly a gather set followed by an output run; the rest is noise
  task automatic run_random(input int n_items);
    int sent;
    int run_len;
    int k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        run_len = $urandom_range(1, 12);
        for (k = 0; k < run_len; k++)
          send_item(grff_pkg::CMD_GATHER, pick_feature(), pick_feature(), pick_feature(),
                    k == run_len - 1, 1'($urandom_range(1)));
        sent += run_len;
        run_len = $urandom_range(1, 12);
        for (k = 0; k < run_len; k++)
          send_item(grff_pkg::CMD_OUTPUT, pick_feature(), pick_feature(), pick_feature(),
                    1'($urandom_range(1)), k == 0);
        sent += run_len;
      end else begin
        run_len = $urandom_range(1, 6);
        for (k = 0; k < run_len; k++)
          send_item(1'($urandom_range(1)), pick_feature(), pick_feature(), pick_feature(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        sent += run_len;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // output items before any gather: the average is still zero
    send_item(grff_pkg::CMD_OUTPUT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0);
    // negative fused result clips to zero
    send_item(grff_pkg::CMD_OUTPUT, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1);

    // set of extremes, then outputs against its average
    send_item(grff_pkg::CMD_GATHER, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
    send_item(grff_pkg::CMD_GATHER, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    send_item(grff_pkg::CMD_GATHER, 16'sh8000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1);
    send_item(grff_pkg::CMD_OUTPUT, 16'shFFFF, 16'sh0001, 16'sh8000, 1'b0, 1'b0);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh4000, 16'sh4000, 16'sh7FFF, 1'b1, 1'b0);

    // set of one item
    send_item(grff_pkg::CMD_GATHER, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1);
    send_item(grff_pkg::CMD_OUTPUT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);

    // random traffic under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 50;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      run_random(355);
    end
    in_valid_i <= 1'b0;

    // drain, then allow for a trailing gather item still in flight
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/grff_pkg.sv
sv/grff_div.sv
sv/gated_residual_feature_fusion.sv
verif/grff_result_checker.sv
verif/tb.sv
